/* src/gbt_pkg.sv */
`timescale 1ns / 1ps
package gbt_pkg;

    localparam int VERTEX_W         = 4;
    localparam int FIELD_VERTICES   = 16;
    localparam int STATUS_W         = 2;
    localparam int CFG_INDEX_W      = 2;
    localparam int CFG_DATA_W       = 5;
    localparam int DEF_MAX_VERTICES = 16;
    localparam int DEF_MAX_EDGES    = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WALK_MODE    = 2'd1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    localparam logic FUNC_ADD      = 1'b0;
    localparam logic FUNC_TRAVERSE = 1'b1;

    localparam logic MODE_BREADTH = 1'b0;
    localparam logic MODE_DEPTH   = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ADD_LINK,
        S_EMIT_STATUS,
        S_B_POP,
        S_B_EDGE,
        S_B_TEST,
        S_D_TOP,
        S_D_TEST,
        S_D_PUSH,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic decode;
        logic add_store;
        logic add_link;
        logic emit_status;
        logic trav_init;
        logic b_pop;
        logic edge_read;
        logic b_test;
        logic d_pop;
        logic d_adv;
        logic push;
        logic produce;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic func;
        logic mode;
        logic add_ok;
        logic tail_valid;
        logic start_ok;
        logic queue_empty;
        logic stack_empty;
        logic top_empty;
        logic cur_empty;
        logic target_new;
        logic can_produce;
        logic slot_free;
        logic pend_valid;
    } stat_t;

endpackage

/* src/gbt_ctrl.sv */
`timescale 1ns / 1ps
module gbt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  gbt_pkg::stat_t stat,
    output gbt_pkg::cmd_t  cmd
);

    gbt_pkg::state_t state_reg;
    gbt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gbt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gbt_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = gbt_pkg::S_DECODE;
                end
            end
            gbt_pkg::S_DECODE:
            begin
                if (stat.func == gbt_pkg::FUNC_ADD)
                begin
                    if (stat.add_ok && stat.tail_valid)
                    begin
                        state_next = gbt_pkg::S_ADD_LINK;
                    end
                    else
                    begin
                        state_next = gbt_pkg::S_EMIT_STATUS;
                    end
                end
                else if (!stat.start_ok)
                begin
                    state_next = gbt_pkg::S_EMIT_STATUS;
                end
                else if (stat.mode == gbt_pkg::MODE_DEPTH)
                begin
                    state_next = gbt_pkg::S_D_TOP;
                end
                else
                begin
                    state_next = gbt_pkg::S_B_POP;
                end
            end
            gbt_pkg::S_ADD_LINK:
            begin
                state_next = gbt_pkg::S_EMIT_STATUS;
            end
            gbt_pkg::S_EMIT_STATUS:
            begin
                if (stat.slot_free)
                begin
                    state_next = gbt_pkg::S_IDLE;
                end
            end
            gbt_pkg::S_B_POP:
            begin
                if (stat.queue_empty)
                begin
                    state_next = gbt_pkg::S_FINISH;
                end
                else if (stat.can_produce)
                begin
                    state_next = gbt_pkg::S_B_EDGE;
                end
            end
            gbt_pkg::S_B_EDGE:
            begin
                if (stat.cur_empty)
                begin
                    state_next = gbt_pkg::S_B_POP;
                end
                else
                begin
                    state_next = gbt_pkg::S_B_TEST;
                end
            end
            gbt_pkg::S_B_TEST:
            begin
                state_next = gbt_pkg::S_B_EDGE;
            end
            gbt_pkg::S_D_TOP:
            begin
                if (stat.stack_empty)
                begin
                    state_next = gbt_pkg::S_FINISH;
                end
                else if (!stat.top_empty)
                begin
                    state_next = gbt_pkg::S_D_TEST;
                end
            end
            gbt_pkg::S_D_TEST:
            begin
                if (stat.target_new)
                begin
                    state_next = gbt_pkg::S_D_PUSH;
                end
                else
                begin
                    state_next = gbt_pkg::S_D_TOP;
                end
            end
            gbt_pkg::S_D_PUSH:
            begin
                if (stat.can_produce)
                begin
                    state_next = gbt_pkg::S_D_TOP;
                end
            end
            gbt_pkg::S_FINISH:
            begin
                if (stat.slot_free)
                begin
                    state_next = gbt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = gbt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            gbt_pkg::S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.latch_in = in_valid;
            end
            gbt_pkg::S_DECODE:
            begin
                cmd.decode    = 1'b1;
                cmd.add_store = (stat.func == gbt_pkg::FUNC_ADD) && stat.add_ok;
                cmd.trav_init = (stat.func == gbt_pkg::FUNC_TRAVERSE) && stat.start_ok;
                // The depth-first walk reports its start vertex straight away.
                cmd.produce   = (stat.func == gbt_pkg::FUNC_TRAVERSE) && stat.start_ok
                                && (stat.mode == gbt_pkg::MODE_DEPTH);
            end
            gbt_pkg::S_ADD_LINK:
            begin
                cmd.add_link = 1'b1;
            end
            gbt_pkg::S_EMIT_STATUS:
            begin
                cmd.emit_status = stat.slot_free;
            end
            gbt_pkg::S_B_POP:
            begin
                cmd.b_pop   = !stat.queue_empty && stat.can_produce;
                cmd.produce = !stat.queue_empty && stat.can_produce;
            end
            gbt_pkg::S_B_EDGE:
            begin
                cmd.edge_read = !stat.cur_empty;
            end
            gbt_pkg::S_B_TEST:
            begin
                cmd.b_test = 1'b1;
                cmd.push   = stat.target_new;
            end
            gbt_pkg::S_D_TOP:
            begin
                cmd.d_pop     = !stat.stack_empty && stat.top_empty;
                cmd.edge_read = !stat.stack_empty && !stat.top_empty;
            end
            gbt_pkg::S_D_TEST:
            begin
                cmd.d_adv = 1'b1;
            end
            gbt_pkg::S_D_PUSH:
            begin
                cmd.push    = stat.can_produce;
                cmd.produce = stat.can_produce;
            end
            gbt_pkg::S_FINISH:
            begin
                cmd.finish = stat.slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* src/gbt_datapath.sv */
`timescale 1ns / 1ps
module gbt_datapath #(
    parameter int MAX_VERTICES = gbt_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = gbt_pkg::DEF_MAX_EDGES
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  gbt_pkg::cmd_t                      cmd,
    output gbt_pkg::stat_t                     stat,
    input  logic                               func,
    input  logic [gbt_pkg::VERTEX_W-1:0]       vertex_a,
    input  logic [gbt_pkg::VERTEX_W-1:0]       vertex_b,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [gbt_pkg::VERTEX_W-1:0]       vertex,
    output logic [gbt_pkg::STATUS_W-1:0]       status,
    output logic                               last,
    input  logic                               cfg_write,
    input  logic [gbt_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [gbt_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int NV = (MAX_VERTICES < gbt_pkg::FIELD_VERTICES) ? MAX_VERTICES
                                                                 : gbt_pkg::FIELD_VERTICES;
    localparam int LW = $clog2(NV);
    localparam int CW = $clog2(NV + 1);
    localparam int AW = $clog2(MAX_EDGES);
    localparam int PW = $clog2(MAX_EDGES + 1);
    localparam logic [PW-1:0] EMPTY_PTR = PW'(MAX_EDGES);
    localparam int VW = gbt_pkg::VERTEX_W;
    localparam int DW = gbt_pkg::CFG_DATA_W;

    typedef struct packed {
        logic [PW-1:0] e;
        logic [VW-1:0] v;
    } frame_t;

    // Configuration.
    logic [DW-1:0] vcount_reg;
    logic          mode_reg;
    logic [DW-1:0] vcount_next;

    // Latched item and its status.
    logic                         func_reg;
    logic [VW-1:0]                a_reg;
    logic [VW-1:0]                b_reg;
    logic [gbt_pkg::STATUS_W-1:0] st_reg;

    // Adjacency lists.
    logic [PW-1:0] head_reg [NV];
    logic [PW-1:0] tail_reg [NV];
    logic [PW-1:0] edges_used_reg;
    logic [AW-1:0] link_reg;
    logic [AW-1:0] new_idx_reg;

    logic [VW-1:0] target_mem [MAX_EDGES];
    logic [PW-1:0] next_mem   [MAX_EDGES];
    logic [VW-1:0] rd_target_reg;
    logic [PW-1:0] rd_next_reg;

    // Walk state.
    logic [NV-1:0] visited_reg;
    frame_t        list_reg [NV];
    logic [CW-1:0] rd_ptr_reg;
    logic [CW-1:0] wr_ptr_reg;
    logic [PW-1:0] cur_e_reg;
    logic          pend_valid_reg;
    logic [VW-1:0] pend_v_reg;

    // Output word register.
    logic                         out_valid_reg;
    logic [VW-1:0]                out_vertex_reg;
    logic [gbt_pkg::STATUS_W-1:0] out_status_reg;
    logic                         out_last_reg;

    logic                         a_ok;
    logic                         b_ok;
    logic                         t_ok;
    logic                         full;
    logic [gbt_pkg::STATUS_W-1:0] add_status;
    logic [LW-1:0]                a_idx;
    logic [LW-1:0]                t_idx;
    logic [LW-1:0]                top_idx;
    logic [LW-1:0]                head_addr;
    logic [LW-1:0]                list_waddr;
    logic [CW-1:0]                wr_m1;
    logic [PW-1:0]                tail_a;
    logic [PW-1:0]                head_q;
    logic                         tail_valid;
    logic [AW-1:0]                e_idx;
    logic [AW-1:0]                edge_addr;
    logic [AW-1:0]                next_waddr;
    logic [PW-1:0]                next_wdata;
    frame_t                       top;
    frame_t                       list_wdata;
    logic                         list_we;
    logic                         slot_free;
    logic [VW-1:0]                prod_v;

    assign a_ok  = {1'b0, a_reg} < vcount_reg;
    assign b_ok  = {1'b0, b_reg} < vcount_reg;
    assign t_ok  = {1'b0, rd_target_reg} < vcount_reg;
    assign full  = edges_used_reg >= EMPTY_PTR;
    assign a_idx = a_reg[LW-1:0];
    assign t_idx = rd_target_reg[LW-1:0];
    assign e_idx = edges_used_reg[AW-1:0];
    assign wr_m1 = wr_ptr_reg - CW'(1);

    assign tail_a     = tail_reg[a_idx];
    assign tail_valid = tail_a < EMPTY_PTR;
    assign head_addr  = cmd.trav_init ? a_idx : t_idx;
    assign head_q     = head_reg[head_addr];

    // Breadth-first reads the queue at its head, depth-first at the top of the stack.
    assign top_idx   = (mode_reg == gbt_pkg::MODE_DEPTH) ? wr_m1[LW-1:0] : rd_ptr_reg[LW-1:0];
    assign top       = list_reg[top_idx];
    assign edge_addr = (mode_reg == gbt_pkg::MODE_DEPTH) ? top.e[AW-1:0] : cur_e_reg[AW-1:0];

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        if (!(a_ok && b_ok))
        begin
            add_status = gbt_pkg::ST_RANGE;
        end
        else if (full)
        begin
            add_status = gbt_pkg::ST_FULL;
        end
        else
        begin
            add_status = gbt_pkg::ST_OK;
        end
    end

    always_comb
    begin
        if (cmd.trav_init)
        begin
            prod_v = a_reg;
        end
        else if (cmd.b_pop)
        begin
            prod_v = top.v;
        end
        else
        begin
            prod_v = rd_target_reg;
        end
    end

    always_comb
    begin
        vcount_next = cfg_data;
        if (cfg_data == '0)
        begin
            vcount_next = DW'(1);
        end
        else if (cfg_data > DW'(NV))
        begin
            vcount_next = DW'(NV);
        end
    end

    always_comb
    begin
        stat             = '0;
        stat.func        = func_reg;
        stat.mode        = mode_reg;
        stat.add_ok      = a_ok && b_ok && !full;
        stat.tail_valid  = tail_valid;
        stat.start_ok    = a_ok;
        stat.queue_empty = rd_ptr_reg == wr_ptr_reg;
        stat.stack_empty = wr_ptr_reg == '0;
        stat.top_empty   = top.e >= EMPTY_PTR;
        stat.cur_empty   = cur_e_reg >= EMPTY_PTR;
        stat.target_new  = t_ok && !visited_reg[t_idx] && (wr_ptr_reg < CW'(NV));
        stat.can_produce = !pend_valid_reg || slot_free;
        stat.slot_free   = slot_free;
        stat.pend_valid  = pend_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= DW'(NV);
            mode_reg   <= gbt_pkg::MODE_BREADTH;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                gbt_pkg::REG_VERTEX_COUNT: vcount_reg <= vcount_next;
                gbt_pkg::REG_WALK_MODE:    mode_reg   <= cfg_data[0];
                default:                   vcount_reg <= vcount_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            func_reg <= func;
            a_reg    <= vertex_a;
            b_reg    <= vertex_b;
        end
        if (cmd.decode)
        begin
            st_reg <= (func_reg == gbt_pkg::FUNC_ADD) ? add_status : gbt_pkg::ST_RANGE;
        end
        if (cmd.add_store)
        begin
            link_reg    <= tail_a[AW-1:0];
            new_idx_reg <= e_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edges_used_reg <= '0;
            for (int i = 0; i < NV; i++)
            begin
                head_reg[i] <= EMPTY_PTR;
                tail_reg[i] <= EMPTY_PTR;
            end
        end
        else if (cmd.add_store)
        begin
            edges_used_reg  <= edges_used_reg + PW'(1);
            tail_reg[a_idx] <= PW'(e_idx);
            if (!tail_valid)
            begin
                head_reg[a_idx] <= PW'(e_idx);
            end
        end
    end

    // Edge table: a new edge is written first, the link from the old tail in the cycle after.
    assign next_waddr = cmd.add_link ? link_reg : e_idx;
    assign next_wdata = cmd.add_link ? PW'(new_idx_reg) : EMPTY_PTR;

    always_ff @(posedge clk)
    begin
        if (cmd.add_store)
        begin
            target_mem[e_idx] <= b_reg;
        end
        if (cmd.add_store || cmd.add_link)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (cmd.edge_read)
        begin
            rd_target_reg <= target_mem[edge_addr];
            rd_next_reg   <= next_mem[edge_addr];
        end
    end

    always_comb
    begin
        list_we    = cmd.trav_init || cmd.push || cmd.d_adv;
        list_waddr = wr_ptr_reg[LW-1:0];
        list_wdata = '{e: head_q, v: rd_target_reg};
        if (cmd.trav_init)
        begin
            list_waddr = '0;
            list_wdata = '{e: head_q, v: a_reg};
        end
        else if (cmd.d_adv)
        begin
            list_waddr = wr_m1[LW-1:0];
            list_wdata = '{e: rd_next_reg, v: top.v};
        end
    end

    always_ff @(posedge clk)
    begin
        if (list_we)
        begin
            list_reg[list_waddr] <= list_wdata;
        end
        if (cmd.b_pop)
        begin
            cur_e_reg <= top.e;
        end
        else if (cmd.b_test)
        begin
            cur_e_reg <= rd_next_reg;
        end
        if (cmd.produce)
        begin
            pend_v_reg <= prod_v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg    <= '0;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.trav_init)
            begin
                // Only the start vertex is marked when a walk begins.
                visited_reg <= NV'(1) << a_idx;
                rd_ptr_reg  <= '0;
                wr_ptr_reg  <= CW'(1);
            end
            else
            begin
                if (cmd.push)
                begin
                    visited_reg[t_idx] <= 1'b1;
                    wr_ptr_reg         <= wr_ptr_reg + CW'(1);
                end
                else if (cmd.d_pop)
                begin
                    wr_ptr_reg <= wr_m1;
                end
                if (cmd.b_pop)
                begin
                    rd_ptr_reg <= rd_ptr_reg + CW'(1);
                end
            end
            // One vertex is held back so that the final word can carry the last flag.
            if (cmd.produce)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.finish)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_status || cmd.finish || (cmd.produce && pend_valid_reg))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_status)
        begin
            out_vertex_reg <= '0;
            out_status_reg <= st_reg;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.finish)
        begin
            out_vertex_reg <= pend_v_reg;
            out_status_reg <= gbt_pkg::ST_OK;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.produce && pend_valid_reg)
        begin
            out_vertex_reg <= pend_v_reg;
            out_status_reg <= gbt_pkg::ST_OK;
            out_last_reg   <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign vertex    = out_vertex_reg;
    assign status    = out_status_reg;
    assign last      = out_last_reg;

endmodule

/* src/graph_bfs_dfs_traversal_core.sv */
// Directed graph store with breadth-first and depth-first walks.
// Input words (func, vertex_a, vertex_b) and result words (vertex, status, last)
// move over valid/ready channels; an input word is taken only while the block is idle.
// func 0 appends the edge vertex_a -> vertex_b and answers with one status word
// (ok, table full, or vertex out of range), issued after a decode state and, when the
// edge joins a non-empty list, a link state; the block is idle again once it is presented.
// func 1 walks from vertex_a and answers with one word per reachable vertex, the
// final one with last set, or with a range status word when vertex_a is out of range;
// walk_mode selects breadth-first or depth-first preorder. Edges are scanned one at
// a time through the single read port of the edge table.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once; they must be
// made by the user only while the block is idle; the block does not enforce this.
// vertex_count saturates to the range 1..MAX_VERTICES, at most 16. Reset empties the
// edge table and every edge list, sets vertex_count to its maximum and selects
// breadth-first order. One result word is held in an output register and one more
// is held back; a stalled receiver pauses the walk at its next result until ready.
`timescale 1ns / 1ps
module graph_bfs_dfs_traversal_core #(
    parameter int MAX_VERTICES = gbt_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = gbt_pkg::DEF_MAX_EDGES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            func,
    input  logic [gbt_pkg::VERTEX_W-1:0]    vertex_a,
    input  logic [gbt_pkg::VERTEX_W-1:0]    vertex_b,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [gbt_pkg::VERTEX_W-1:0]    vertex,
    output logic [gbt_pkg::STATUS_W-1:0]    status,
    output logic                            last,
    input  logic                            cfg_write,
    input  logic [gbt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gbt_pkg::CFG_DATA_W-1:0]  cfg_data
);

    gbt_pkg::cmd_t  cmd;
    gbt_pkg::stat_t stat;

    gbt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gbt_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .func      (func),
        .vertex_a  (vertex_a),
        .vertex_b  (vertex_b),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .vertex    (vertex),
        .status    (status),
        .last      (last),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

`ifndef SYNTH
    a_idle_flushed: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !stat.pend_valid)
        else $error("held vertex left behind when the block went idle");

    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.latch_in, cmd.decode, cmd.add_link, cmd.emit_status, cmd.b_pop,
                  cmd.edge_read, cmd.b_test, cmd.d_pop, cmd.d_adv, cmd.finish}))
        else $error("more than one controller step issued in a cycle");

    a_status_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != gbt_pkg::ST_OK)) |-> ((vertex == '0) && last))
        else $error("error status word without zero vertex and last flag");

    a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (out_valid && last))
        else $error("end of walk did not present a final word");
`endif

endmodule
